### hdl/qmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmp_pkg: shared types and constants of the quadrature modulator
// Register indexes, reset values, the level record passed from the front to
// the back, and the sine table generator used at elaboration.
// ----------------------------------------------------------------------------
package qmp_pkg;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_STEP    = 2'd0,
        CFG_SYMBOL_LENGTH = 2'd1,
        CFG_LFSR_SEED     = 2'd2
    } t_cfg_index;

    localparam int STEP_BITS   = 32;
    localparam int SYMLEN_BITS = 16;
    localparam int LFSR_BITS   = 9;

    localparam logic [STEP_BITS-1:0]   RST_PHASE_STEP    = 32'd858993459;
    localparam logic [SYMLEN_BITS-1:0] RST_SYMBOL_LENGTH = 16'd250;
    localparam logic [LFSR_BITS-1:0]   RST_LFSR_SEED     = 9'd250;

    // Sample format
    localparam int SAMPLE_BITS = 16;
    localparam int ROM_BITS    = 15;      // unsigned Q1.14, up to 16384
    localparam int SUM_BITS    = 17;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = 17'sd32767;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sd32767;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Levels of one item after the symbol update
    typedef struct packed {
        logic i_level;
        logic q_level;
        logic symbol_start;
    } t_levels;

    // Restoring division, only evaluated while the sine table is built
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry k of a quarter-wave table: round(16384*sin(pi/2*k/2^abits)),
    // integer Taylor series in Q30.
    function automatic logic [ROM_BITS-1:0] sine_entry(input int k, input int abits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned rnd;
        longint unsigned dv;
        x    = (HALF_PI_Q30 * longint'(k)) >> abits;
        x2   = (x * x) >> 30;
        sum  = longint'(x);
        term = x;
        for (int n = 1; n < 40; n++) begin
            dv   = longint'((2 * n) * (2 * n + 1));
            term = (term * x2) >> 30;
            term = div_u64(term, dv);
            if (term == 0) begin
                break;
            end
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        rnd = (longint'(sum) + 64'd32768) >> 16;
        return rnd[ROM_BITS-1:0];
    endfunction

endpackage

### hdl/qmp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmp_in_if: input item channel
// One tick item carrying the restart flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qmp_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

### hdl/qmp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmp_out_if: result item channel
// Modulated sample with the current levels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               in_phase_level;
    logic               quadrature_level;
    logic               symbol_start;

    modport source (output valid, output sample, output in_phase_level,
                    output quadrature_level, output symbol_start, input ready);
    modport sink   (input valid, input sample, input in_phase_level,
                    input quadrature_level, input symbol_start, output ready);
endinterface

### hdl/qmp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmp_fifo: short item queue
// Register-based FIFO between the front and the back, one push and one pop
// per cycle.
// ----------------------------------------------------------------------------
module qmp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_avail
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

### hdl/qmp_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmp_sine_rom: quarter-wave sine table
// 2^ADDR_BITS + 1 entries in Q1.14, two registered read ports sharing one
// enable.
// ----------------------------------------------------------------------------
module qmp_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [ADDR_BITS:0]  i_addr_a,
    input  logic [ADDR_BITS:0]  i_addr_b,
    output logic [14:0]         o_data_a,
    output logic [14:0]         o_data_b
);
    import qmp_pkg::*;

    localparam int ENTRIES = (1 << ADDR_BITS) + 1;

    logic [ROM_BITS-1:0] rom_tbl [ENTRIES];
    logic [ROM_BITS-1:0] r_data_a, r_data_b;

    // Table contents fixed at elaboration
    for (genvar g = 0; g < ENTRIES; g++) begin : g_tbl
        localparam logic [ROM_BITS-1:0] VAL = sine_entry(g, ADDR_BITS);
        assign rom_tbl[g] = VAL;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= rom_tbl[i_addr_a];
            r_data_b <= rom_tbl[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;
endmodule

### hdl/qmp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmp_front: tick intake and symbol state
// Holds the configuration, phase accumulator, sample counter, LFSR and
// levels; each accepted item is stamped with its phase and levels and queued.
// ----------------------------------------------------------------------------
module qmp_front #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int COUNT_BITS      = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [qmp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [qmp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // item intake
    input  logic                            i_valid,
    input  logic                            i_restart,
    output logic                            o_ready,
    // queue side
    input  logic                            i_full,
    output logic                            o_push,
    output logic [1:0]                      o_quad,
    output logic [TABLE_ADDR_BITS-1:0]      o_index,
    output qmp_pkg::t_levels                o_levels
);
    import qmp_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > SYMLEN_BITS) ? COUNT_BITS : SYMLEN_BITS;

    logic [STEP_BITS-1:0]   r_phase_step;
    logic [SYMLEN_BITS-1:0] r_symbol_length;
    logic [LFSR_BITS-1:0]   r_lfsr_seed;

    logic [PHASE_BITS-1:0]  r_phase, n_phase, cur_phase, step_s;
    logic [COUNT_BITS-1:0]  r_count, n_count, cur_count, inc_count;
    logic [LFSR_BITS-1:0]   r_lfsr, n_lfsr, cur_lfsr;
    logic                   r_i_level, n_i_level;
    logic                   r_q_level, n_q_level;
    logic                   sym;
    logic                   accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step    <= RST_PHASE_STEP;
            r_symbol_length <= RST_SYMBOL_LENGTH;
            r_lfsr_seed     <= RST_LFSR_SEED;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:    r_phase_step    <= i_cfg_data[STEP_BITS-1:0];
                CFG_SYMBOL_LENGTH: r_symbol_length <= i_cfg_data[SYMLEN_BITS-1:0];
                CFG_LFSR_SEED:     r_lfsr_seed     <= i_cfg_data[LFSR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Step scaled to the accumulator width
    if (PHASE_BITS >= STEP_BITS) begin : g_step_up
        assign step_s = PHASE_BITS'(r_phase_step) << (PHASE_BITS - STEP_BITS);
    end else begin : g_step_down
        assign step_s = r_phase_step[STEP_BITS-1 -: PHASE_BITS];
    end

    // Restart applies before this item
    assign cur_phase = i_restart ? '0 : r_phase;
    assign cur_count = i_restart ? '0 : r_count;
    assign cur_lfsr  = i_restart ? r_lfsr_seed : r_lfsr;
    assign sym       = (cur_count == '0);
    assign inc_count = cur_count + 1'b1;

    // Next state of one tick
    always_comb begin
        n_phase   = cur_phase + step_s;
        n_count   = inc_count;
        n_lfsr    = cur_lfsr;
        n_i_level = r_i_level;
        n_q_level = r_q_level;
        if (r_symbol_length <= SYMLEN_BITS'(1)
            || CMP_BITS'(inc_count) >= CMP_BITS'(r_symbol_length)) begin
            n_count = '0;
        end
        if (sym) begin
            n_q_level = r_i_level;
            n_i_level = cur_lfsr[2];
            n_lfsr    = {cur_lfsr[0] ^ cur_lfsr[4], cur_lfsr[LFSR_BITS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_count   <= '0;
            r_lfsr    <= RST_LFSR_SEED;
            r_i_level <= 1'b1;
            r_q_level <= 1'b1;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_lfsr    <= n_lfsr;
            r_i_level <= n_i_level;
            r_q_level <= n_q_level;
        end
    end

    // Queued record: table position of the pre-increment phase and levels
    assign o_push                = accept;
    assign o_quad                = cur_phase[PHASE_BITS-1 -: 2];
    assign o_index               = cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign o_levels.i_level      = n_i_level;
    assign o_levels.q_level      = n_q_level;
    assign o_levels.symbol_start = sym;
endmodule

### hdl/qmp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmp_back: sample synthesis
// Looks up sine and cosine in the quarter-wave table, applies the levels,
// adds and saturates, and holds the result in the output register.
// ----------------------------------------------------------------------------
module qmp_back #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // queue side
    input  logic                        i_avail,
    input  logic [1:0]                  i_quad,
    input  logic [TABLE_ADDR_BITS-1:0]  i_index,
    input  qmp_pkg::t_levels            i_levels,
    output logic                        o_pop,
    // result side
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic signed [15:0]          o_sample,
    output logic                        o_in_phase_level,
    output logic                        o_quadrature_level,
    output logic                        o_symbol_start
);
    import qmp_pkg::*;

    localparam int AW = TABLE_ADDR_BITS + 1;
    localparam logic [AW-1:0] QUARTER = AW'(1) << TABLE_ADDR_BITS;

    logic          adv;
    logic [1:0]    quad_cos;
    logic [AW-1:0] addr_sin, addr_cos;
    logic [ROM_BITS-1:0] rom_sin, rom_cos;

    logic          r_v1;
    logic          r_neg_sin, r_neg_cos;
    t_levels       r_lv1;

    logic signed [SUM_BITS-1:0] term_sin, term_cos, acc;
    logic          r_v2;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    t_levels       r_lv2;

    // Whole back pipeline moves when the output register is free
    assign adv   = !r_v2 || i_ready;
    assign o_pop = adv && i_avail;

    // Quadrant folding; cosine is sine a quarter turn ahead
    assign quad_cos = i_quad + 2'd1;
    assign addr_sin = i_quad[0]   ? QUARTER - AW'(i_index) : AW'(i_index);
    assign addr_cos = quad_cos[0] ? QUARTER - AW'(i_index) : AW'(i_index);

    qmp_sine_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_addr_a (addr_sin),
        .i_addr_b (addr_cos),
        .o_data_a (rom_sin),
        .o_data_b (rom_cos)
    );

    // Stage 1: table read alongside signs and levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // sine term carries Q, cosine term carries I
            r_neg_sin <= i_quad[1] ^ !i_levels.q_level;
            r_neg_cos <= quad_cos[1] ^ !i_levels.i_level;
            r_lv1     <= i_levels;
        end
    end

    // Stage 2: sum and saturate
    assign term_sin = r_neg_sin ? -$signed({2'b00, rom_sin}) : $signed({2'b00, rom_sin});
    assign term_cos = r_neg_cos ? -$signed({2'b00, rom_cos}) : $signed({2'b00, rom_cos});
    assign acc      = term_sin + term_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sample <= (acc > SUM_MAX) ? SAMPLE_MAX : acc[SAMPLE_BITS-1:0];
            r_lv2    <= r_lv1;
        end
    end

    assign o_valid            = r_v2;
    assign o_sample           = r_sample;
    assign o_in_phase_level   = r_lv2.i_level;
    assign o_quadrature_level = r_lv2.q_level;
    assign o_symbol_start     = r_lv2.symbol_start;
endmodule

### hdl/quadrature_modulator_prbs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_modulator_prbs: QPSK-style modulator with a PRBS9 bit source
// Each input item (a tick with a restart flag) gives one output item: the
// saturated sample I*cos + Q*sin and the current I/Q levels.
//
// Channels: i_in carries the tick, o_out the sample; both valid/ready.
// Configuration: i_cfg_wr_en/i_cfg_index/i_cfg_data, written while idle;
// index 0 phase step, 1 symbol length, 2 LFSR seed.
// Throughput: one item per clock while o_out.ready stays high. After the edge
// that accepts the tick, the item passes the queue register, the table read
// and the output register before the sample is on o_out.
// The front takes ticks while the queue has room; a four-entry queue lets the
// front keep running while the back waits on the output.
// Reset (synchronous, active low): configuration to its defaults, phase and
// sample count to zero, LFSR to the default seed, both levels to +1, queue
// and pipeline empty.
// When the receiver stalls, the output register holds its item, the back
// stops, the queue fills and then i_in.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module quadrature_modulator_prbs #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int COUNT_BITS      = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [qmp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [qmp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    qmp_in_if.sink                             i_in,
    qmp_out_if.source                          o_out
);
    import qmp_pkg::*;

    localparam int ENTRY_BITS = TABLE_ADDR_BITS + 2 + $bits(t_levels);

    logic                       push, pop, full, avail;
    logic [1:0]                 f_quad, b_quad;
    logic [TABLE_ADDR_BITS-1:0] f_index, b_index;
    t_levels                    f_levels, b_levels;
    logic [ENTRY_BITS-1:0]      q_in, q_out;

    qmp_front #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in.valid),
        .i_restart   (i_in.restart),
        .o_ready     (i_in.ready),
        .i_full      (full),
        .o_push      (push),
        .o_quad      (f_quad),
        .o_index     (f_index),
        .o_levels    (f_levels)
    );

    assign q_in = {f_index, f_quad, f_levels};
    assign {b_index, b_quad, b_levels} = q_out;

    qmp_fifo #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_avail (avail)
    );

    qmp_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_avail            (avail),
        .i_quad             (b_quad),
        .i_index            (b_index),
        .i_levels           (b_levels),
        .o_pop              (pop),
        .i_ready            (o_out.ready),
        .o_valid            (o_out.valid),
        .o_sample           (o_out.sample),
        .o_in_phase_level   (o_out.in_phase_level),
        .o_quadrature_level (o_out.quadrature_level),
        .o_symbol_start     (o_out.symbol_start)
    );
endmodule

### verif/quadrature_modulator_prbs_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_modulator_prbs_tb: self-checking bench of the PRBS9 modulator
// A short table of directed ticks covers the range ends, a zero seed, a zero
// symbol length and a length lowered below the running count. Random ticks
// follow under several register settings. Every sample item is compared with
// a fixed table value or a bit-exact model of NCO, PRBS9 source and I/Q levels.
// ----------------------------------------------------------------------------
module quadrature_modulator_prbs_tb;
    import qmp_pkg::*;

    localparam int IDLE_LIMIT   = 4000;    // cycles with no accepted item
    localparam int DRAIN_CYCLES = 8;       // idle margin after the last item is taken
    localparam int SEGMENTS     = 6;
    localparam int SEG_ITEMS    = 258;
    localparam int TABLE_N      = 1024;
    localparam longint unsigned HALF_PI_FIX  = 64'd1686629713;   // pi/2 in Q30
    localparam logic [31:0]     QUARTER_TURN = 32'h4000_0000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          i_lvl;
        logic                          q_lvl;
        logic                          sym;
    } t_mod_sample;

    // One row of the directed table: a register write or a tick
    typedef struct packed {
        logic                     is_cfg;
        t_cfg_index               idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic                     restart;
        logic                     typed;
        t_mod_sample              want;
    } t_dir_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    qmp_in_if  tick_ch ();
    qmp_out_if sample_ch ();

    quadrature_modulator_prbs dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (tick_ch),
        .o_out       (sample_ch)
    );

    // Model state and registers
    int                     sine_quarter [0:TABLE_N];
    logic [31:0]            nco_phase;
    logic [15:0]            sym_count;
    logic [LFSR_BITS-1:0]   prbs_reg;
    logic                   lvl_i;
    logic                   lvl_q;
    logic [STEP_BITS-1:0]   phase_step_r;
    logic [SYMLEN_BITS-1:0] symbol_len_r;
    logic [LFSR_BITS-1:0]   prbs_seed_r;

    t_mod_sample expected_samples [$];
    t_dir_row    directed_rows [$];
    t_mod_sample monitor_want;
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Quarter-wave entry: round(16384*sin(pi/2*k/1024)) by a Q30 Taylor series
    function automatic int quarter_wave_entry(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        int              n;
        x    = (HALF_PI_FIX * k) >> 10;
        x2   = (x * x) >> 30;
        acc  = x;
        term = x;
        for (n = 1; n < 40 && term != 0; n++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return int'((acc + 32768) >> 16);
    endfunction

    // Sine of a phase: top two bits pick the quadrant, next ten the entry
    function automatic int wave_at(input logic [31:0] ph);
        int mag;
        if (ph[30]) begin
            mag = sine_quarter[TABLE_N - int'(ph[29:20])];
        end else begin
            mag = sine_quarter[ph[29:20]];
        end
        return ph[31] ? -mag : mag;
    endfunction

    // Advance the model by one tick and return the sample it produces
    function automatic t_mod_sample next_sample(input logic restart);
        t_mod_sample r;
        logic        sym;
        logic        data_bit;
        int          sin_v;
        int          cos_v;
        int          total;
        logic [15:0] cnt_next;
        if (restart) begin
            prbs_reg  = prbs_seed_r;
            nco_phase = '0;
            sym_count = '0;
        end
        sym = (sym_count == 16'd0);
        if (sym) begin
            lvl_q    = lvl_i;
            data_bit = prbs_reg[2];
            prbs_reg = {prbs_reg[0] ^ prbs_reg[4], prbs_reg[8:1]};
            lvl_i    = data_bit;
        end
        // phase before this tick's increment
        sin_v = wave_at(nco_phase);
        cos_v = wave_at(nco_phase + QUARTER_TURN);
        total = (lvl_i ? cos_v : -cos_v) + (lvl_q ? sin_v : -sin_v);
        if (total > 32767) begin
            total = 32767;
        end else if (total < -32768) begin
            total = -32768;
        end
        nco_phase = nco_phase + phase_step_r;
        cnt_next  = sym_count + 16'd1;
        if (symbol_len_r <= 16'd1 || cnt_next >= symbol_len_r) begin
            cnt_next = '0;
        end
        sym_count = cnt_next;
        r.sample  = 16'(total);
        r.i_lvl   = lvl_i;
        r.q_lvl   = lvl_q;
        r.sym     = sym;
        return r;
    endfunction

    // Table row builders
    function automatic t_dir_row cfg_row(input t_cfg_index idx, input logic [31:0] val);
        t_dir_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = val;
        return r;
    endfunction

    function automatic t_dir_row tick_row(input logic restart);
        t_dir_row r;
        r         = '0;
        r.restart = restart;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input logic restart, input logic signed [15:0] s,
                                           input logic i_lvl, input logic q_lvl,
                                           input logic sym);
        t_dir_row r;
        r         = '0;
        r.restart = restart;
        r.typed   = 1'b1;
        r.want    = '{sample: s, i_lvl: i_lvl, q_lvl: q_lvl, sym: sym};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Hold ticks until every pending sample item has been taken
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        cfg_wr_en     <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PHASE_STEP:    phase_step_r = val;
            CFG_SYMBOL_LENGTH: symbol_len_r = val[SYMLEN_BITS-1:0];
            CFG_LFSR_SEED:     prbs_seed_r  = val[LFSR_BITS-1:0];
            default: ;
        endcase
    endtask

    // Offer one tick item; returns at the edge that accepts it
    task automatic send_tick(input logic restart, input logic typed, input t_mod_sample want);
        t_mod_sample pred;
        cfg_wr_en <= 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart;
        do @(negedge i_clk); while (!tick_ch.ready);
        @(posedge i_clk);
        pred = next_sample(restart);
        expected_samples.push_back(typed ? want : pred);
    endtask

    // Receiver: random back-pressure
    initial begin
        sample_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            sample_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Output check, sampled mid-cycle where everything is settled
    always @(negedge i_clk) begin
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("sample item with nothing pending", sample_ch.sample, 0);
            end else begin
                monitor_want = expected_samples.pop_front();
                if (sample_ch.sample !== monitor_want.sample)
                    report_mismatch("sample", sample_ch.sample, monitor_want.sample);
                if (sample_ch.in_phase_level !== monitor_want.i_lvl)
                    report_mismatch("in_phase_level", sample_ch.in_phase_level,
                                    monitor_want.i_lvl);
                if (sample_ch.quadrature_level !== monitor_want.q_lvl)
                    report_mismatch("quadrature_level", sample_ch.quadrature_level,
                                    monitor_want.q_lvl);
                if (sample_ch.symbol_start !== monitor_want.sym)
                    report_mismatch("symbol_start", sample_ch.symbol_start, monitor_want.sym);
            end
        end
    end

    // Watchdog: no item moving on either channel for too long
    always @(negedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) ||
            (sample_ch.valid && sample_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int          seg;
        int          n;
        int          ri;
        int          base_tx;
        int          base_rx;
        logic        restart_bit;
        logic        prev_cfg;
        logic [31:0] step_val;
        logic [31:0] len_val;
        logic [31:0] seed_val;
        t_dir_row    row;

        i_rst_n         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= CFG_PHASE_STEP;
        cfg_data        <= '0;
        tick_ch.valid   <= 1'b0;
        tick_ch.restart <= 1'b0;

        for (n = 0; n <= TABLE_N; n++) begin
            sine_quarter[n] = quarter_wave_entry(n);
        end
        phase_step_r = RST_PHASE_STEP;
        symbol_len_r = RST_SYMBOL_LENGTH;
        prbs_seed_r  = RST_LFSR_SEED;
        nco_phase    = '0;
        sym_count    = '0;
        prbs_reg     = RST_LFSR_SEED;
        lvl_i        = 1'b1;
        lvl_q        = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset: seed bit 2 is zero, phase zero gives -cos
        directed_rows.push_back(typed_row(1'b0, -16'sd16384, 1'b0, 1'b1, 1'b1));
        repeat (3) directed_rows.push_back(tick_row(1'b0));
        directed_rows.push_back(tick_row(1'b1));
        // Zero step, zero length (update every tick), zero seed (I stays -1)
        directed_rows.push_back(cfg_row(CFG_PHASE_STEP, 32'h0000_0000));
        directed_rows.push_back(cfg_row(CFG_SYMBOL_LENGTH, 32'h0000_0000));
        directed_rows.push_back(cfg_row(CFG_LFSR_SEED, 32'h0000_0000));
        directed_rows.push_back(tick_row(1'b1));
        repeat (3) directed_rows.push_back(typed_row(1'b0, -16'sd16384, 1'b0, 1'b0, 1'b1));
        // Top of every register range
        directed_rows.push_back(cfg_row(CFG_PHASE_STEP, 32'hFFFF_FFFF));
        directed_rows.push_back(cfg_row(CFG_SYMBOL_LENGTH, 32'h0000_FFFF));
        directed_rows.push_back(cfg_row(CFG_LFSR_SEED, 32'h0000_01FF));
        directed_rows.push_back(tick_row(1'b1));
        repeat (4) directed_rows.push_back(tick_row(1'b0));
        // Length lowered below the running count, quarter-turn step
        directed_rows.push_back(cfg_row(CFG_PHASE_STEP, 32'h4000_0000));
        directed_rows.push_back(cfg_row(CFG_SYMBOL_LENGTH, 32'h0000_0003));
        repeat (5) directed_rows.push_back(tick_row(1'b0));
        directed_rows.push_back(tick_row(1'b1));
        // Smallest nonzero seed, half-turn step, length one
        directed_rows.push_back(cfg_row(CFG_LFSR_SEED, 32'h0000_0001));
        directed_rows.push_back(cfg_row(CFG_PHASE_STEP, 32'h8000_0000));
        directed_rows.push_back(cfg_row(CFG_SYMBOL_LENGTH, 32'h0000_0001));
        repeat (2) directed_rows.push_back(tick_row(1'b0));
        directed_rows.push_back(tick_row(1'b1));
        directed_rows.push_back(tick_row(1'b0));

        tx_idle_pct = 20;
        rx_idle_pct = 81;
        prev_cfg    = 1'b0;
        for (ri = 0; ri < directed_rows.size(); ri++) begin
            row = directed_rows[ri];
            if (row.is_cfg) begin
                if (!prev_cfg) begin
                    wait_drained();
                end
                write_reg(row.idx, row.data);
            end else begin
                send_tick(row.restart, row.typed, row.want);
            end
            prev_cfg = row.is_cfg;
        end

        // Random segments, two per idling mode
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0:       begin base_tx = 20; base_rx = 81; end
                1:       begin base_tx = 81; base_rx = 20; end
                default: begin base_tx = 0;  base_rx = 0;  end
            endcase
            case ($urandom_range(3))
                0:       step_val = $urandom_range(32'h0010_0000);
                1:       step_val = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
                default: step_val = $urandom;
            endcase
            case ($urandom_range(9))
                0:       len_val = 32'h0;
                1:       len_val = 32'hFFFF;
                2:       len_val = $urandom_range(400, 13);
                default: len_val = $urandom_range(12, 1);
            endcase
            seed_val = ($urandom_range(7) == 0) ? 32'h0 : $urandom_range(511, 1);
            wait_drained();
            write_reg(CFG_PHASE_STEP, step_val);
            write_reg(CFG_SYMBOL_LENGTH, len_val);
            write_reg(CFG_LFSR_SEED, seed_val);

            for (n = 0; n < SEG_ITEMS; n++) begin
                // now and then a stretch with no idling at all
                if (n % 43 == 0) begin
                    if ($urandom_range(3) == 0) begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end else begin
                        tx_idle_pct = base_tx;
                        rx_idle_pct = base_rx;
                    end
                end
                // sender holds off until all pending samples are out
                if ((seg == 0 && n == 100) || $urandom_range(199) == 0) begin
                    wait_drained();
                end
                if (n == 0) begin
                    restart_bit = $urandom_range(1);
                end else begin
                    restart_bit = ($urandom_range(31) == 0);
                end
                send_tick(restart_bit, 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
